/* hdl/rsa_mexp_pkg.sv */
// ----------------------------------------------------------------------------
// RSA modular exponentiation - shared package
// Register map codes, mode codes, reset values and the handshake structs
// between the top level and the exponentiation sequencer.
// ----------------------------------------------------------------------------
package rsa_mexp_pkg;

  // width of the symbol field on the input stream
  localparam int unsigned SYMBOL_W = 16;
  // width of the value field on the output stream
  localparam int unsigned VALUE_W = 17;
  // offset between a character code and its plaintext residue
  localparam int unsigned CHAR_OFFSET = 96;

  // register reset values
  localparam int unsigned MODULUS_RST = 20803;
  localparam int unsigned ENC_EXP_RST = 11;
  localparam int unsigned DEC_EXP_RST = 7331;

  // mode carried in tuser
  localparam logic FUNC_ENCRYPT = 1'b0;
  localparam logic FUNC_DECRYPT = 1'b1;

  // configuration register index
  typedef enum logic [1:0] {
    REG_MODULUS = 2'd0,
    REG_ENC_EXP = 2'd1,
    REG_DEC_EXP = 2'd2
  } reg_idx_e;

  // top level -> sequencer
  typedef struct packed {
    logic start;  // input transaction accepted this cycle
    logic func;   // mode of that transaction
    logic take;   // finished result moves to the output register
  } seq_ctrl_t;

  // sequencer -> top level
  typedef struct packed {
    logic idle;   // ready for a new symbol
    logic done;   // result waiting
    logic func;   // mode of the waiting result
  } seq_stat_t;

endpackage

/* hdl/rsa_mexp_addmod.sv */
// ----------------------------------------------------------------------------
// RSA modular exponentiation - modular adder
// Computes (a + b + cin) mod m for a, b below m, with one add and one
// compare-subtract. The reduction and product steps of the sequencer use it.
// ----------------------------------------------------------------------------
module rsa_mexp_addmod #(
  parameter int unsigned WIDTH = 16
) (
  input  logic [WIDTH-1:0] a_i,
  input  logic [WIDTH-1:0] b_i,
  input  logic             cin_i,
  input  logic [WIDTH-1:0] m_i,
  output logic [WIDTH-1:0] y_o
);

  logic [WIDTH:0] sum;
  logic [WIDTH:0] diff;

  always_comb begin
    sum  = {1'b0, a_i} + {1'b0, b_i} + {{WIDTH{1'b0}}, cin_i};
    diff = sum - {1'b0, m_i};
    // sum stays below 2m, so one subtraction reduces it
    y_o  = (sum >= {1'b0, m_i}) ? diff[WIDTH-1:0] : sum[WIDTH-1:0];
  end

endmodule

/* hdl/rsa_mexp_seq.sv */
// ----------------------------------------------------------------------------
// RSA modular exponentiation - sequencer
// Reduces the symbol modulo n bit by bit, then runs MSB-first
// square-and-multiply; each modular product is a double-and-add loop over
// the multiplier bits. The reduction and product steps share one modular adder.
// ----------------------------------------------------------------------------
module rsa_mexp_seq #(
  parameter int unsigned MOD_WIDTH = 16,
  parameter int unsigned EXP_WIDTH = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rsa_mexp_pkg::seq_ctrl_t            ctrl_i,
  input  logic [rsa_mexp_pkg::SYMBOL_W-1:0]  symbol_i,
  input  logic [MOD_WIDTH-1:0]               modulus_i,
  input  logic [EXP_WIDTH-1:0]               enc_exp_i,
  input  logic [EXP_WIDTH-1:0]               dec_exp_i,
  output rsa_mexp_pkg::seq_stat_t            stat_o,
  output logic [MOD_WIDTH-1:0]               res_o
);

  localparam int unsigned MBW = $clog2(MOD_WIDTH);
  localparam int unsigned EBW = $clog2(EXP_WIDTH);
  localparam int unsigned SBW = $clog2(rsa_mexp_pkg::SYMBOL_W);
  localparam int unsigned SW  = rsa_mexp_pkg::SYMBOL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_NEGFIX,
    ST_MUL_DBL,
    ST_MUL_ADD,
    ST_MUL_END,
    ST_DONE
  } state_e;

  state_e               state_q;
  logic                 func_q;
  logic                 neg_q;
  logic                 sq_q;
  logic [SW-1:0]        sym_q;
  logic [SBW-1:0]       scnt_q;
  logic [MOD_WIDTH-1:0] red_q;
  logic [MOD_WIDTH-1:0] base_q;
  logic [MOD_WIDTH-1:0] opa_q;
  logic [MOD_WIDTH-1:0] mop_q;
  logic [MOD_WIDTH-1:0] prod_q;
  logic [MOD_WIDTH-1:0] res_q;
  logic [MBW-1:0]       mbit_q;
  logic [EBW-1:0]       ebit_q;
  logic [EXP_WIDTH-1:0] exp_q;

  logic [MOD_WIDTH-1:0] m_eff;
  logic                 mod_small;
  logic [SW-1:0]        sym_off;
  logic                 sym_neg;
  logic [MOD_WIDTH-1:0] ua;
  logic [MOD_WIDTH-1:0] ub;
  logic                 ucin;
  logic [MOD_WIDTH-1:0] uy;

  // a modulus below two acts as one
  assign mod_small = (modulus_i < MOD_WIDTH'(2));
  assign m_eff     = mod_small ? MOD_WIDTH'(1) : modulus_i;

  always_comb begin
    sym_neg = (symbol_i < SW'(rsa_mexp_pkg::CHAR_OFFSET));
    if (ctrl_i.func == rsa_mexp_pkg::FUNC_DECRYPT) begin
      sym_off = symbol_i;
      sym_neg = 1'b0;
    end else if (sym_neg) begin
      sym_off = SW'(rsa_mexp_pkg::CHAR_OFFSET) - symbol_i;
    end else begin
      sym_off = symbol_i - SW'(rsa_mexp_pkg::CHAR_OFFSET);
    end
  end

  // operand select for the shared modular adder
  always_comb begin
    case (state_q)
      ST_REDUCE: begin
        ua   = red_q;
        ub   = red_q;
        ucin = sym_q[SW-1];
      end
      ST_MUL_ADD: begin
        ua   = prod_q;
        ub   = opa_q;
        ucin = 1'b0;
      end
      default: begin
        ua   = prod_q;
        ub   = prod_q;
        ucin = 1'b0;
      end
    endcase
  end

  rsa_mexp_addmod #(
    .WIDTH (MOD_WIDTH)
  ) u_addmod (
    .a_i   (ua),
    .b_i   (ub),
    .cin_i (ucin),
    .m_i   (m_eff),
    .y_o   (uy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      func_q  <= rsa_mexp_pkg::FUNC_ENCRYPT;
      neg_q   <= 1'b0;
      sq_q    <= 1'b0;
      sym_q   <= '0;
      scnt_q  <= '0;
      red_q   <= '0;
      base_q  <= '0;
      opa_q   <= '0;
      mop_q   <= '0;
      prod_q  <= '0;
      res_q   <= '0;
      mbit_q  <= '0;
      ebit_q  <= '0;
      exp_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (ctrl_i.start) begin
            func_q  <= ctrl_i.func;
            neg_q   <= sym_neg;
            sym_q   <= sym_off;
            scnt_q  <= SBW'(SW - 1);
            red_q   <= '0;
            exp_q   <= (ctrl_i.func == rsa_mexp_pkg::FUNC_DECRYPT) ? dec_exp_i : enc_exp_i;
            state_q <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          // shift one symbol bit into the remainder
          red_q <= uy;
          sym_q <= sym_q << 1;
          if (scnt_q == '0) begin
            state_q <= ST_NEGFIX;
          end else begin
            scnt_q <= scnt_q - SBW'(1);
          end
        end
        ST_NEGFIX: begin
          base_q <= (neg_q && (red_q != '0)) ? (m_eff - red_q) : red_q;
          if (exp_q == '0) begin
            res_q   <= MOD_WIDTH'(1);
            state_q <= ST_DONE;
          end else if (mod_small) begin
            res_q   <= '0;
            state_q <= ST_DONE;
          end else begin
            // first square of the running power, which starts at one
            opa_q   <= MOD_WIDTH'(1);
            mop_q   <= MOD_WIDTH'(1);
            prod_q  <= '0;
            mbit_q  <= MBW'(MOD_WIDTH - 1);
            ebit_q  <= EBW'(EXP_WIDTH - 1);
            sq_q    <= 1'b1;
            state_q <= ST_MUL_DBL;
          end
        end
        ST_MUL_DBL: begin
          prod_q <= uy;
          mop_q  <= mop_q << 1;
          if (mop_q[MOD_WIDTH-1]) begin
            state_q <= ST_MUL_ADD;
          end else if (mbit_q == '0) begin
            state_q <= ST_MUL_END;
          end else begin
            mbit_q <= mbit_q - MBW'(1);
          end
        end
        ST_MUL_ADD: begin
          prod_q <= uy;
          if (mbit_q == '0) begin
            state_q <= ST_MUL_END;
          end else begin
            mbit_q  <= mbit_q - MBW'(1);
            state_q <= ST_MUL_DBL;
          end
        end
        ST_MUL_END: begin
          mbit_q <= MBW'(MOD_WIDTH - 1);
          prod_q <= '0;
          if (sq_q && exp_q[EXP_WIDTH-1]) begin
            // exponent bit set: multiply by the base
            opa_q   <= prod_q;
            mop_q   <= base_q;
            sq_q    <= 1'b0;
            state_q <= ST_MUL_DBL;
          end else if (ebit_q == '0) begin
            res_q   <= prod_q;
            state_q <= ST_DONE;
          end else begin
            ebit_q  <= ebit_q - EBW'(1);
            exp_q   <= exp_q << 1;
            opa_q   <= prod_q;
            mop_q   <= prod_q;
            sq_q    <= 1'b1;
            state_q <= ST_MUL_DBL;
          end
        end
        ST_DONE: begin
          if (ctrl_i.take) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign stat_o.idle = (state_q == ST_IDLE);
  assign stat_o.done = (state_q == ST_DONE);
  assign stat_o.func = func_q;
  assign res_o       = res_q;

  // remainder and partial product stay reduced
  a_red_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REDUCE) |-> (red_q < m_eff))
    else $error("remainder not reduced below modulus");

  a_prod_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_MUL_DBL) || (state_q == ST_MUL_ADD) || (state_q == ST_MUL_END))
      |-> (prod_q < m_eff))
    else $error("partial product not reduced below modulus");

  a_take_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_DONE) && ctrl_i.take) |=> (state_q == ST_IDLE))
    else $error("sequencer did not release after result was taken");

endmodule

/* hdl/rsa_mexp_top.sv */
// ----------------------------------------------------------------------------
// RSA modular exponentiation - top level
//
//  channel  dir  handshake                 payload
//  s_axis   in   s_axis_tvalid/tready      tdata[15:0] symbol, tuser func
//  m_axis   out  m_axis_tvalid/tready      tdata[16:0] value
//  apb      in   psel/penable/pwrite       paddr, pwdata, prdata
//
//  One symbol takes a bit-serial reduction, setup and, per exponent bit, a
//  squaring made of double steps over the multiplier bits and add steps for
//  its ones, plus a multiply by the base when the bit is set; the whole is
//  bound by the one modular adder.
//  Reset returns all state to its reset values; the block is ready as soon as reset is released.
//  s_axis_tready is low while a symbol is in work or its result cannot move
//  into the output register; a stalled output holds its value.
// ----------------------------------------------------------------------------
module rsa_modular_exponentiation #(
  parameter int unsigned MOD_WIDTH = 16,
  parameter int unsigned EXP_WIDTH = 16,
  localparam int unsigned DATA_W   = ((MOD_WIDTH > 32) || (EXP_WIDTH > 32)) ? 64 : 32,
  localparam int unsigned ADDR_LSB = (DATA_W == 64) ? 3 : 2,
  localparam int unsigned ADDR_W   = ADDR_LSB + 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [15:0]       s_axis_tdata,  // [15:0] symbol
  input  logic              s_axis_tuser,  // [0] func
  // output stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [23:0]       m_axis_tdata,  // [16:0] value, [23:17] zero
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned RES_W = ((MOD_WIDTH > 16) ? MOD_WIDTH : 16) + 1;
  localparam int unsigned VW    = rsa_mexp_pkg::VALUE_W;

  logic [MOD_WIDTH-1:0] modulus_q;
  logic [EXP_WIDTH-1:0] enc_exp_q;
  logic [EXP_WIDTH-1:0] dec_exp_q;
  logic [VW-1:0]        value_q;
  logic                 out_valid_q;

  rsa_mexp_pkg::reg_idx_e  reg_idx;
  rsa_mexp_pkg::seq_ctrl_t ctrl;
  rsa_mexp_pkg::seq_stat_t stat;
  logic [MOD_WIDTH-1:0]    res;
  logic [RES_W-1:0]        value_full;
  logic                    s_accept;
  logic                    cfg_write;

  // configuration registers
  assign pready    = 1'b1;
  assign reg_idx   = rsa_mexp_pkg::reg_idx_e'(paddr[ADDR_W-1:ADDR_LSB]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= MOD_WIDTH'(rsa_mexp_pkg::MODULUS_RST);
      enc_exp_q <= EXP_WIDTH'(rsa_mexp_pkg::ENC_EXP_RST);
      dec_exp_q <= EXP_WIDTH'(rsa_mexp_pkg::DEC_EXP_RST);
    end else if (cfg_write) begin
      case (reg_idx)
        rsa_mexp_pkg::REG_MODULUS: modulus_q <= pwdata[MOD_WIDTH-1:0];
        rsa_mexp_pkg::REG_ENC_EXP: enc_exp_q <= pwdata[EXP_WIDTH-1:0];
        rsa_mexp_pkg::REG_DEC_EXP: dec_exp_q <= pwdata[EXP_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rsa_mexp_pkg::REG_MODULUS: prdata = DATA_W'(modulus_q);
      rsa_mexp_pkg::REG_ENC_EXP: prdata = DATA_W'(enc_exp_q);
      rsa_mexp_pkg::REG_DEC_EXP: prdata = DATA_W'(dec_exp_q);
      default:                   prdata = '0;
    endcase
  end

  // stream control
  assign s_axis_tready = stat.idle;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign ctrl.start    = s_accept;
  assign ctrl.func     = s_axis_tuser;
  assign ctrl.take     = stat.done && (!out_valid_q || m_axis_tready);

  rsa_mexp_seq #(
    .MOD_WIDTH (MOD_WIDTH),
    .EXP_WIDTH (EXP_WIDTH)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .symbol_i  (s_axis_tdata),
    .modulus_i (modulus_q),
    .enc_exp_i (enc_exp_q),
    .dec_exp_i (dec_exp_q),
    .stat_o    (stat),
    .res_o     (res)
  );

  // decrypt adds the character offset back
  assign value_full = (stat.func == rsa_mexp_pkg::FUNC_DECRYPT)
                    ? RES_W'(res) + RES_W'(rsa_mexp_pkg::CHAR_OFFSET)
                    : RES_W'(res);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      value_q     <= '0;
    end else if (ctrl.take) begin
      out_valid_q <= 1'b1;
      value_q     <= value_full[VW-1:0];
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(24 - VW){1'b0}}, value_q};

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready)
    else $error("input accepted again while a symbol is in work");

endmodule
